FILE: rtl/rcfc_pkg.sv
// rcfc_pkg: constants and types for the radio control frame checker
// no dependencies; imported by rc_frame_checker_with_link_loss_core
`default_nettype none

package rcfc_pkg;

  localparam int unsigned NUM_STICKS  = 4;
  localparam int unsigned NUM_FLAGS   = 3;

  // frame byte positions
  localparam logic [4:0] POS_HDR0      = 5'd0;
  localparam logic [4:0] POS_HDR1      = 5'd1;
  localparam logic [4:0] POS_HDR2      = 5'd2;
  localparam logic [4:0] POS_LEN       = 5'd3;
  localparam logic [4:0] POS_STICK0    = 5'd4;
  localparam logic [4:0] POS_FLAG0     = 5'd12;
  localparam logic [4:0] POS_SUM_END   = 5'd15;
  localparam logic [4:0] POS_FRAME_END = 5'd19;

  localparam logic [7:0] PAYLOAD_LEN = 8'd11;

  localparam logic [15:0] LOSS_LIMIT_RST = 16'd250;

  // input opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_HEADER_FIRST  = 2'd0;
  localparam logic [1:0] CFG_HEADER_SECOND = 2'd1;
  localparam logic [1:0] CFG_HEADER_THIRD  = 2'd2;
  localparam logic [1:0] CFG_LOSS_LIMIT    = 2'd3;

  typedef logic [15:0] stick_t;
  typedef logic [7:0]  flag_t;

  typedef struct packed {
    logic   packet_valid;
    logic   connected;
    stick_t throttle;
    stick_t yaw;
    stick_t roll;
    stick_t pitch;
    flag_t  hold_height;
    flag_t  power_down;
    flag_t  unlock_flight;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/rc_frame_checker_with_link_loss_core.sv
// Radio control frame checker with link-loss detection, top level
// depends on rcfc_pkg
//
// Usage:
//   Input channel (in_valid / in_stall): one transaction per packet byte
//   (in_opcode = 0, in_last on the final byte) or per empty poll
//   (in_opcode = 1). Each finished packet or poll yields one result
//   transaction on the output channel (out_valid / out_stall); non-final
//   bytes yield none. A result carries the pass flag, the link status and
//   the stick and flag values of the last good packet.
//   Configuration: cfg_wr_en with cfg_index / cfg_wdata writes the header
//   bytes and the loss limit; write only while the block is idle.
//   Checking: an item is checked while it sits in the input register and
//   its result is registered into the result queue when it has room.
//   Throughput: one item per cycle while the result queue has room, set by
//   the single check stage between the input register and a two-entry
//   result queue.
//   Stall: when the result queue is full the input register holds its
//   item and in_stall rises; nothing is dropped.
//   Reset: synchronous rst_n clears assembly, held values, loss counter
//   (link down) and restores header bytes 0 and loss limit 250.
`default_nettype none

module rc_frame_checker_with_link_loss_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [15:0]     cfg_wdata,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            in_opcode,
  input  wire logic [7:0]      in_data_byte,
  input  wire logic            in_last,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 out_packet_valid,
  output logic                 out_connected,
  output rcfc_pkg::stick_t     out_throttle,
  output rcfc_pkg::stick_t     out_yaw,
  output rcfc_pkg::stick_t     out_roll,
  output rcfc_pkg::stick_t     out_pitch,
  output rcfc_pkg::flag_t      out_hold_height,
  output rcfc_pkg::flag_t      out_power_down,
  output rcfc_pkg::flag_t      out_unlock_flight
);
  import rcfc_pkg::*;

  // configuration
  logic [7:0]  hdr0_r, hdr1_r, hdr2_r;
  logic [15:0] loss_limit_r;

  // input register
  logic        in_v_r;
  logic        op_r;
  logic [7:0]  byte_r;
  logic        last_r;

  // frame assembly and link state
  logic [4:0]  pos_r, pos_nxt;
  logic [11:0] sum_r, sum_nxt;
  logic        ok_r, ok_nxt;
  logic [31:0] rsum_r, rsum_nxt;
  stick_t      staged_stick_r [NUM_STICKS];
  stick_t      staged_stick_nxt [NUM_STICKS];
  flag_t       staged_flag_r [NUM_FLAGS];
  flag_t       staged_flag_nxt [NUM_FLAGS];
  stick_t      held_stick_r [NUM_STICKS];
  stick_t      held_stick_nxt [NUM_STICKS];
  flag_t       held_flag_r [NUM_FLAGS];
  flag_t       held_flag_nxt [NUM_FLAGS];
  logic [15:0] loss_r, loss_nxt;
  logic        link_r, link_nxt;

  // result queue
  result_t     rq_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r, cnt_nxt;

  logic        proceed;
  logic        push;
  logic        pop;
  logic        pkt_pass;
  logic [16:0] loss_inc;
  result_t     res;

  assign proceed  = in_v_r && (cnt_r != 2'd2);
  assign in_stall = in_v_r && !proceed;
  assign pop      = (cnt_r != 2'd0) && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr0_r       <= '0;
      hdr1_r       <= '0;
      hdr2_r       <= '0;
      loss_limit_r <= LOSS_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HEADER_FIRST:  hdr0_r       <= cfg_wdata[7:0];
        CFG_HEADER_SECOND: hdr1_r       <= cfg_wdata[7:0];
        CFG_HEADER_THIRD:  hdr2_r       <= cfg_wdata[7:0];
        CFG_LOSS_LIMIT:    loss_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r   <= in_opcode;
      byte_r <= in_data_byte;
      last_r <= in_last;
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    ok_nxt   = ok_r;
    rsum_nxt = rsum_r;
    loss_nxt = loss_r;
    link_nxt = link_r;
    staged_stick_nxt = staged_stick_r;
    staged_flag_nxt  = staged_flag_r;
    held_stick_nxt   = held_stick_r;
    held_flag_nxt    = held_flag_r;
    push     = 1'b0;
    pkt_pass = 1'b0;
    loss_inc = {1'b0, loss_r} + 17'd1;

    if (proceed) begin
      if (op_r == OP_BYTE && pos_r < POS_FRAME_END) begin
        if (pos_r < POS_SUM_END) begin
          sum_nxt = sum_r + {4'd0, byte_r};
        end
        if (pos_r == POS_HDR0 && byte_r != hdr0_r) ok_nxt = 1'b0;
        if (pos_r == POS_HDR1 && byte_r != hdr1_r) ok_nxt = 1'b0;
        if (pos_r == POS_HDR2 && byte_r != hdr2_r) ok_nxt = 1'b0;
        if (pos_r == POS_LEN && byte_r != PAYLOAD_LEN) ok_nxt = 1'b0;
        // sticks are big-endian: even position is the high byte
        for (int i = 0; i < NUM_STICKS; i++) begin
          if (pos_r == POS_STICK0 + 5'(2 * i)) begin
            staged_stick_nxt[i][15:8] = byte_r;
          end
          if (pos_r == POS_STICK0 + 5'(2 * i + 1)) begin
            staged_stick_nxt[i][7:0] = byte_r;
          end
        end
        for (int j = 0; j < NUM_FLAGS; j++) begin
          if (pos_r == POS_FLAG0 + 5'(j)) begin
            staged_flag_nxt[j] = byte_r;
          end
        end
        if (pos_r >= POS_SUM_END) begin
          rsum_nxt = {rsum_r[23:0], byte_r};
        end
        pos_nxt = pos_r + 5'd1;
      end

      if (op_r == OP_POLL || last_r) begin
        push     = 1'b1;
        pkt_pass = (op_r == OP_BYTE) && ok_nxt && (pos_nxt >= POS_FRAME_END) &&
                   (rsum_nxt == {20'd0, sum_nxt});
        // end of transaction: clear assembly
        pos_nxt  = '0;
        sum_nxt  = '0;
        ok_nxt   = 1'b1;
        rsum_nxt = '0;
        if (pkt_pass) begin
          loss_nxt       = '0;
          link_nxt       = 1'b1;
          held_stick_nxt = staged_stick_nxt;
          held_flag_nxt  = staged_flag_nxt;
        end else if (loss_inc >= {1'b0, loss_limit_r}) begin
          // saturate at the limit and drop the link
          loss_nxt = loss_limit_r;
          link_nxt = 1'b0;
        end else begin
          loss_nxt = loss_inc[15:0];
        end
      end
    end

    res.packet_valid  = pkt_pass;
    res.connected     = link_nxt;
    res.throttle      = held_stick_nxt[0];
    res.yaw           = held_stick_nxt[1];
    res.roll          = held_stick_nxt[2];
    res.pitch         = held_stick_nxt[3];
    res.hold_height   = held_flag_nxt[0];
    res.power_down    = held_flag_nxt[1];
    res.unlock_flight = held_flag_nxt[2];

    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      ok_r   <= 1'b1;
      rsum_r <= '0;
      loss_r <= '0;
      link_r <= 1'b0;
      for (int i = 0; i < NUM_STICKS; i++) begin
        staged_stick_r[i] <= '0;
        held_stick_r[i]   <= '0;
      end
      for (int j = 0; j < NUM_FLAGS; j++) begin
        staged_flag_r[j] <= '0;
        held_flag_r[j]   <= '0;
      end
    end else begin
      pos_r          <= pos_nxt;
      sum_r          <= sum_nxt;
      ok_r           <= ok_nxt;
      rsum_r         <= rsum_nxt;
      loss_r         <= loss_nxt;
      link_r         <= link_nxt;
      staged_stick_r <= staged_stick_nxt;
      staged_flag_r  <= staged_flag_nxt;
      held_stick_r   <= held_stick_nxt;
      held_flag_r    <= held_flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rq_r[wr_ptr_r] <= res;
    end
  end

  assign out_valid         = (cnt_r != 2'd0);
  assign out_packet_valid  = rq_r[rd_ptr_r].packet_valid;
  assign out_connected     = rq_r[rd_ptr_r].connected;
  assign out_throttle      = rq_r[rd_ptr_r].throttle;
  assign out_yaw           = rq_r[rd_ptr_r].yaw;
  assign out_roll          = rq_r[rd_ptr_r].roll;
  assign out_pitch         = rq_r[rd_ptr_r].pitch;
  assign out_hold_height   = rq_r[rd_ptr_r].hold_height;
  assign out_power_down    = rq_r[rd_ptr_r].power_down;
  assign out_unlock_flight = rq_r[rd_ptr_r].unlock_flight;

endmodule

`default_nettype wire
